@@ rtl/core/assert_macros.svh @@
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent on one edge forces the consequent on the same edge
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// antecedent on one edge forces the consequent on the next edge
`define ASSERT_IMPLY_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/msr_pkg.sv @@
package msr_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int RND_W    = 32;
	localparam int PROD_W   = RND_W + CNT_W;

	typedef logic [1:0] action_t;
	typedef logic [1:0] status_t;

	localparam action_t ACT_INSERT = 2'd0;
	localparam action_t ACT_REMOVE = 2'd1;
	localparam action_t ACT_SAMPLE = 2'd2;

	localparam status_t ST_DONE  = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	typedef struct packed {
		logic load;      // latch a new beat, restart the scan
		logic scan_en;   // issue next scan read, compare previous one
		logic rd_last;   // read the last stored entry
		logic wr_move;   // move last entry into the matched slot
		logic wr_ins;    // append the value
		logic mul;       // scale random word by occupancy
		logic rd_smp;    // read the sampled entry
		logic cap_smp;   // capture the sampled entry
		logic set_flag;
		logic set_full;
		logic set_empty;
		logic load_out;  // move the result into the output register
	} dp_cmd_t;

	typedef struct packed {
		action_t action;
		logic    full;
		logic    empty;
		logic    match;
		logic    miss;
	} dp_sts_t;

endpackage

@@ rtl/core/msr_req_if.sv @@
interface msr_req_if;
	logic                                valid;
	logic                                ready;
	msr_pkg::action_t                    action;
	logic signed [msr_pkg::DATA_W-1:0]   value;
	logic        [msr_pkg::RND_W-1:0]    random_word;

	modport source (output valid, action, value, random_word, input ready);
	modport sink   (input valid, action, value, random_word, output ready);
endinterface

@@ rtl/core/msr_rsp_if.sv @@
interface msr_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                flag;
	logic signed [msr_pkg::DATA_W-1:0]   sampled_value;
	msr_pkg::status_t                    status;

	modport source (output valid, flag, sampled_value, status, input ready);
	modport sink   (input valid, flag, sampled_value, status, output ready);
endinterface

@@ rtl/core/msr_ram.sv @@
module msr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/msr_dp.sv @@
module msr_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  msr_pkg::dp_cmd_t                  cmd,
	output msr_pkg::dp_sts_t                  sts,
	input  msr_pkg::action_t                  action,
	input  logic signed [msr_pkg::DATA_W-1:0] value,
	input  logic [msr_pkg::RND_W-1:0]         random_word,
	output logic                              flag,
	output logic signed [msr_pkg::DATA_W-1:0] sampled_value,
	output msr_pkg::status_t                  status
);

	msr_pkg::action_t               act_q;
	logic [msr_pkg::DATA_W-1:0]     val_q;
	logic [msr_pkg::RND_W-1:0]      rnd_q;
	logic [msr_pkg::CNT_W-1:0]      occ_q;
	logic [msr_pkg::CNT_W-1:0]      scan_q;
	logic                           pend_s1;
	logic [msr_pkg::ADDR_W-1:0]     idx_s1;
	logic [msr_pkg::ADDR_W-1:0]     pos_q;
	logic [msr_pkg::PROD_W-1:0]     prod_s1;
	logic                           flag_q;
	msr_pkg::status_t               status_q;
	logic [msr_pkg::DATA_W-1:0]     smp_q;
	logic                           out_flag_q;
	msr_pkg::status_t               out_status_q;
	logic [msr_pkg::DATA_W-1:0]     out_smp_q;

	logic [msr_pkg::CNT_W-1:0]      last_cnt;
	logic [msr_pkg::ADDR_W-1:0]     raddr;
	logic [msr_pkg::ADDR_W-1:0]     waddr;
	logic [msr_pkg::DATA_W-1:0]     wdata;
	logic                           we;
	logic [msr_pkg::DATA_W-1:0]     rdata;
	logic                           scan_more;

	assign last_cnt  = occ_q - msr_pkg::CNT_W'(1);
	assign scan_more = scan_q < occ_q;

	always_comb begin
		priority if (cmd.rd_last) begin
			raddr = last_cnt[msr_pkg::ADDR_W-1:0];
		end else if (cmd.rd_smp) begin
			raddr = prod_s1[msr_pkg::RND_W +: msr_pkg::ADDR_W];
		end else begin
			raddr = scan_q[msr_pkg::ADDR_W-1:0];
		end
	end

	assign we    = cmd.wr_move | cmd.wr_ins;
	assign waddr = cmd.wr_move ? pos_q : occ_q[msr_pkg::ADDR_W-1:0];
	assign wdata = cmd.wr_move ? rdata : val_q;

	msr_ram #(
		.WIDTH (msr_pkg::DATA_W),
		.DEPTH (msr_pkg::CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			scan_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (cmd.load) begin
				scan_q  <= '0;
				pend_s1 <= 1'b0;
			end else if (cmd.scan_en) begin
				pend_s1 <= scan_more;
				if (scan_more) begin
					scan_q <= scan_q + msr_pkg::CNT_W'(1);
				end
			end
			if (cmd.wr_ins) begin
				occ_q <= occ_q + msr_pkg::CNT_W'(1);
			end else if (cmd.wr_move) begin
				occ_q <= last_cnt;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q    <= action;
			val_q    <= value;
			rnd_q    <= random_word;
			flag_q   <= 1'b0;
			status_q <= msr_pkg::ST_DONE;
			smp_q    <= '0;
		end else begin
			if (cmd.set_flag) flag_q <= 1'b1;
			if (cmd.set_full) status_q <= msr_pkg::ST_FULL;
			if (cmd.set_empty) status_q <= msr_pkg::ST_EMPTY;
			if (cmd.cap_smp) smp_q <= rdata;
		end
		if (cmd.scan_en) begin
			idx_s1 <= scan_q[msr_pkg::ADDR_W-1:0];
		end
		if (sts.match && cmd.scan_en) begin
			pos_q <= idx_s1;
		end
		if (cmd.mul) begin
			prod_s1 <= {{msr_pkg::CNT_W{1'b0}}, rnd_q} * {{msr_pkg::RND_W{1'b0}}, occ_q};
		end
		if (cmd.load_out) begin
			out_flag_q   <= flag_q;
			out_status_q <= status_q;
			out_smp_q    <= smp_q;
		end
	end

	assign sts.action = act_q;
	assign sts.full   = occ_q == msr_pkg::CNT_W'(msr_pkg::CAPACITY);
	assign sts.empty  = occ_q == '0;
	assign sts.match  = pend_s1 && (rdata == val_q);
	assign sts.miss   = !pend_s1 && (scan_q == occ_q);

	assign flag          = out_flag_q;
	assign status        = out_status_q;
	assign sampled_value = $signed(out_smp_q);

endmodule

@@ rtl/core/msr_ctrl.sv @@
module msr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output msr_pkg::dp_cmd_t cmd,
	input  msr_pkg::dp_sts_t sts
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_SCAN     = 4'd2;
	localparam logic [3:0] S_RD_LAST  = 4'd3;
	localparam logic [3:0] S_MOVE_WR  = 4'd4;
	localparam logic [3:0] S_INS_WR   = 4'd5;
	localparam logic [3:0] S_MUL      = 4'd6;
	localparam logic [3:0] S_SMP_RD   = 4'd7;
	localparam logic [3:0] S_SMP_CAP  = 4'd8;
	localparam logic [3:0] S_DONE     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.action)
					msr_pkg::ACT_INSERT: begin
						if (sts.full) begin
							cmd.set_full = 1'b1;
							state_d      = S_DONE;
						end else begin
							state_d = S_SCAN;
						end
					end
					msr_pkg::ACT_REMOVE: state_d = S_SCAN;
					msr_pkg::ACT_SAMPLE: begin
						if (sts.empty) begin
							cmd.set_empty = 1'b1;
							state_d       = S_DONE;
						end else begin
							state_d = S_MUL;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				priority if (sts.match) begin
					state_d = (sts.action == msr_pkg::ACT_REMOVE) ? S_RD_LAST : S_INS_WR;
				end else if (sts.miss) begin
					if (sts.action == msr_pkg::ACT_INSERT) begin
						cmd.set_flag = 1'b1;
						state_d      = S_INS_WR;
					end else begin
						state_d = S_DONE;
					end
				end else begin
					// keep scanning
					state_d = S_SCAN;
				end
			end
			S_RD_LAST: begin
				cmd.rd_last = 1'b1;
				state_d     = S_MOVE_WR;
			end
			S_MOVE_WR: begin
				cmd.wr_move  = 1'b1;
				cmd.set_flag = 1'b1;
				state_d      = S_DONE;
			end
			S_INS_WR: begin
				cmd.wr_ins = 1'b1;
				state_d    = S_DONE;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SMP_RD;
			end
			S_SMP_RD: begin
				cmd.rd_smp = 1'b1;
				state_d    = S_SMP_CAP;
			end
			S_SMP_CAP: begin
				cmd.cap_smp = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/multiset_random_sampler.sv @@
// one beat in flight at a time; the result sits in an output register so a new beat
// is taken as soon as the previous result is registered, even while it waits
// insert and remove: one store read per entry, a match ends the scan early
// sample: multiply, store read, capture; full or empty cases and code 3 go straight to the result
// reset: occupancy and handshake state cleared; store contents stay undefined, no sweep
`include "assert_macros.svh"

module multiset_random_sampler (
	input  logic      clk,
	input  logic      arst_n,
	msr_req_if.sink   req,
	msr_rsp_if.source rsp
);

	msr_pkg::dp_cmd_t cmd;
	msr_pkg::dp_sts_t sts;

	msr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	msr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (req.action),
		.value         (req.value),
		.random_word   (req.random_word),
		.flag          (rsp.flag),
		.sampled_value (rsp.sampled_value),
		.status        (rsp.status)
	);

	`ASSERT_IMPLY(a_no_ins_full, cmd.wr_ins, !sts.full, "append into a full store")
	`ASSERT_IMPLY(a_no_move_empty, cmd.wr_move, !sts.empty, "move out of an empty store")
	`ASSERT_IMPLY(a_no_overwrite, cmd.load_out, !rsp.valid || rsp.ready, "pending result overwritten")
	`ASSERT_IMPLY_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "second beat taken while busy")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT   = 6_000_000;
	localparam int SETTLE_CYCLES = msr_pkg::CAPACITY + 64;
	localparam int MAX_IDLE      = 18;
	localparam int RANDOM_ITEMS  = 543;
	localparam int QUIET_EVERY   = 150;
	localparam msr_pkg::action_t ACT_UNUSED = 2'd3;

	typedef struct packed {
		msr_pkg::action_t                   action;
		logic signed [msr_pkg::DATA_W-1:0]  value;
		logic        [msr_pkg::RND_W-1:0]   random_word;
	} request_t;

	typedef struct packed {
		logic                               flag;
		logic signed [msr_pkg::DATA_W-1:0]  sampled_value;
		msr_pkg::status_t                   status;
	} outcome_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	msr_req_if req_ch ();
	msr_rsp_if rsp_ch ();

	multiset_random_sampler i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow copy of the multiset, updated when a request beat is taken
	logic signed [msr_pkg::DATA_W-1:0] set_store [msr_pkg::CAPACITY];
	int                                set_count = 0;

	request_t pending_q [$];
	outcome_t outcome_q [$];

	int queued_items  = 0;
	int settled_items = 0;
	int mismatches    = 0;
	int cycle_count   = 0;

	int       send_gap;
	int       recv_stall;
	int       stall_next;
	bit       send_bursty;
	bit       recv_bursty;
	request_t next_req;
	outcome_t got_out;
	outcome_t want_out;

	logic signed [msr_pkg::DATA_W-1:0] value_pool [8] = '{
		32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, -32'sd1,
		32'sd1, 32'sd7, 32'shA5A5_A5A5, 32'sh5A5A_5A5A
	};

	function automatic outcome_t step_multiset(request_t r);
		outcome_t                          o;
		int                                hit;
		logic [2*msr_pkg::RND_W-1:0]       scaled;
		o   = '0;
		hit = -1;
		// lowest-index match
		for (int k = set_count - 1; k >= 0; k--) begin
			if (set_store[k] == r.value)
				hit = k;
		end
		case (r.action)
			msr_pkg::ACT_INSERT: begin
				if (set_count >= msr_pkg::CAPACITY) begin
					o.status = msr_pkg::ST_FULL;
				end else begin
					o.flag = (hit < 0);
					set_store[set_count] = r.value;
					set_count++;
				end
			end
			msr_pkg::ACT_REMOVE: begin
				if (hit >= 0) begin
					set_store[hit] = set_store[set_count - 1];
					set_count--;
					o.flag = 1'b1;
				end
			end
			msr_pkg::ACT_SAMPLE: begin
				if (set_count == 0) begin
					o.status = msr_pkg::ST_EMPTY;
				end else begin
					scaled = (2*msr_pkg::RND_W)'(r.random_word)
					         * (2*msr_pkg::RND_W)'(set_count);
					o.sampled_value = set_store[scaled[2*msr_pkg::RND_W-1:msr_pkg::RND_W]];
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic int idle_draw(bit bursty);
		return bursty ? 0 : int'($urandom_range(MAX_IDLE));
	endfunction

	function automatic logic signed [msr_pkg::DATA_W-1:0] pick_value();
		if ($urandom_range(1) == 0)
			return value_pool[$urandom_range(7)];
		return $urandom;
	endfunction

	function automatic logic signed [msr_pkg::DATA_W-1:0] stored_value();
		if (set_count == 0)
			return pick_value();
		return set_store[$urandom_range(set_count - 1)];
	endfunction

	function automatic logic [msr_pkg::RND_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_item(msr_pkg::action_t a, logic signed [msr_pkg::DATA_W-1:0] v,
	                          logic [msr_pkg::RND_W-1:0] w);
		pending_q.insert(pending_q.size(), request_t'{action: a, value: v, random_word: w});
		queued_items++;
	endtask

	task automatic wait_quiet();
		while (settled_items != queued_items)
			@(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid       <= 1'b0;
			req_ch.action      <= msr_pkg::ACT_INSERT;
			req_ch.value       <= '0;
			req_ch.random_word <= '0;
			send_gap           <= 0;
			send_bursty        <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				outcome_q.insert(outcome_q.size(), step_multiset(
					'{action: req_ch.action, value: req_ch.value,
					  random_word: req_ch.random_word}));
			if (req_ch.valid && !req_ch.ready) begin
				// beat still waiting, hold it
			end else if (send_gap > 0) begin
				req_ch.valid <= 1'b0;
				send_gap     <= send_gap - 1;
			end else if (pending_q.size() > 0) begin
				next_req            = pending_q.pop_front();
				req_ch.valid       <= 1'b1;
				req_ch.action      <= next_req.action;
				req_ch.value       <= next_req.value;
				req_ch.random_word <= next_req.random_word;
				send_gap           <= idle_draw(send_bursty);
				if ($urandom_range(31) == 0)
					send_bursty <= !send_bursty;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor and backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_stall   <= 0;
			recv_bursty  <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_out = '{flag: rsp_ch.flag, sampled_value: rsp_ch.sampled_value,
				            status: rsp_ch.status};
				if (outcome_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: flag %0b value %0d status %0d",
						         got_out.flag, got_out.sampled_value, got_out.status);
				end else begin
					want_out = outcome_q.pop_front();
					if (got_out.flag !== want_out.flag
					    || got_out.sampled_value !== want_out.sampled_value
					    || got_out.status !== want_out.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected flag %0b value %0d status %0d",
							         settled_items, want_out.flag, want_out.sampled_value,
							         want_out.status,
							         ", got flag %0b value %0d status %0d",
							         got_out.flag, got_out.sampled_value, got_out.status);
					end
				end
				settled_items++;
				stall_next = idle_draw(recv_bursty);
				if ($urandom_range(31) == 0)
					recv_bursty <= !recv_bursty;
			end else begin
				stall_next = (recv_stall > 0) ? recv_stall - 1 : 0;
			end
			recv_stall   <= stall_next;
			rsp_ch.ready <= (stall_next == 0);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("multiset_random_sampler verification failed");
			$finish;
		end
	end

	initial begin
		int                                pick;
		int                                insert_cut;
		logic signed [msr_pkg::DATA_W-1:0] absent_val;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty store, extremes, duplicates, swap-with-last removal
		queue_item(msr_pkg::ACT_SAMPLE, 32'sd5, '1);
		queue_item(msr_pkg::ACT_REMOVE, 32'sd5, '0);
		queue_item(ACT_UNUSED, $urandom, $urandom);
		queue_item(msr_pkg::ACT_INSERT, 32'sh8000_0000, '0);
		queue_item(msr_pkg::ACT_INSERT, 32'sh7FFF_FFFF, '1);
		queue_item(msr_pkg::ACT_INSERT, 32'sd0, $urandom);
		queue_item(msr_pkg::ACT_INSERT, -32'sd1, $urandom);
		queue_item(msr_pkg::ACT_INSERT, 32'sh7FFF_FFFF, $urandom);
		queue_item(msr_pkg::ACT_SAMPLE, 32'sd0, '0);
		queue_item(msr_pkg::ACT_SAMPLE, 32'sd0, '1);
		queue_item(msr_pkg::ACT_SAMPLE, -32'sd1, 32'h8000_0000);
		queue_item(msr_pkg::ACT_REMOVE, 32'sh7FFF_FFFF, '0);
		queue_item(msr_pkg::ACT_REMOVE, 32'sd12345, '1);
		queue_item(msr_pkg::ACT_REMOVE, 32'sh8000_0000, $urandom);
		queue_item(ACT_UNUSED, 32'sh7FFF_FFFF, '1);
		queue_item(msr_pkg::ACT_INSERT, 32'sh5555_5555, $urandom);
		queue_item(msr_pkg::ACT_INSERT, 32'shAAAA_AAAA, $urandom);
		queue_item(msr_pkg::ACT_SAMPLE, $urandom, $urandom);
		queue_item(msr_pkg::ACT_REMOVE, -32'sd1, $urandom);
		queue_item(msr_pkg::ACT_REMOVE, 32'sd0, $urandom);
		queue_item(msr_pkg::ACT_REMOVE, 32'sh7FFF_FFFF, $urandom);
		queue_item(msr_pkg::ACT_REMOVE, 32'sh5555_5555, $urandom);
		queue_item(msr_pkg::ACT_REMOVE, 32'shAAAA_AAAA, $urandom);
		queue_item(msr_pkg::ACT_SAMPLE, $urandom, $urandom);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			while (pending_q.size() >= 2)
				@(posedge clk);
			if (n % QUIET_EVERY == QUIET_EVERY - 1)
				wait_quiet();
			pick = $urandom_range(99);
			// keep the store small so scans stay short
			insert_cut = (set_count > 40) ? 25 : 45;
			if (pick < insert_cut)
				queue_item(msr_pkg::ACT_INSERT, pick_value(), pick_word());
			else if (pick < 75)
				queue_item(msr_pkg::ACT_REMOVE,
				           ($urandom_range(4) != 0) ? stored_value() : pick_value(),
				           pick_word());
			else if (pick < 95)
				queue_item(msr_pkg::ACT_SAMPLE, pick_value(), pick_word());
			else
				queue_item(ACT_UNUSED, pick_value(), pick_word());
		end

		// closing mix: inserts, extreme sample words, present and absent removals
		wait_quiet();
		repeat (3)
			queue_item(msr_pkg::ACT_INSERT, pick_value(), pick_word());
		queue_item(msr_pkg::ACT_SAMPLE, pick_value(), '0);
		queue_item(msr_pkg::ACT_SAMPLE, pick_value(), '1);
		queue_item(msr_pkg::ACT_SAMPLE, pick_value(), $urandom);
		queue_item(msr_pkg::ACT_SAMPLE, pick_value(), $urandom);
		queue_item(msr_pkg::ACT_REMOVE, stored_value(), $urandom);
		queue_item(msr_pkg::ACT_INSERT, pick_value(), $urandom);
		queue_item(msr_pkg::ACT_INSERT, pick_value(), $urandom);
		wait_quiet();
		absent_val = $urandom;
		for (int k = 0; k < set_count; k++) begin
			if (set_store[k] == absent_val) begin
				absent_val = $urandom;
				k = -1;
			end
		end
		queue_item(msr_pkg::ACT_REMOVE, absent_val, $urandom);
		queue_item(ACT_UNUSED, pick_value(), pick_word());
		queue_item(msr_pkg::ACT_SAMPLE, pick_value(), pick_word());

		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outcome_q.size() == 0)
			$display("multiset_random_sampler verification clean");
		else
			$display("multiset_random_sampler verification failed");
		$finish;
	end

endmodule

@@ multiset_random_sampler.f @@
+incdir+rtl/core
rtl/core/msr_pkg.sv
rtl/core/msr_req_if.sv
rtl/core/msr_rsp_if.sv
rtl/core/msr_ram.sv
rtl/core/msr_dp.sv
rtl/core/msr_ctrl.sv
rtl/core/multiset_random_sampler.sv
test/tb_top.sv
